### design/inverse_trig_unit_defines.svh
// Assertion macros shared by the inverse trigonometric unit.
// No dependencies; define ASSERT_OFF to compile the checks away.
`ifndef INVERSE_TRIG_UNIT_DEFINES_SVH
`define INVERSE_TRIG_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define ITU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ITU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ITU_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define ITU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/itu_pkg.sv
// Types, constants and helper functions of the inverse trigonometric unit.
// No dependencies; imported by every module of the unit.
package itu_pkg;

    localparam int INPUT_FRAC_BITS  = 16;
    localparam int OUTPUT_FRAC_BITS = 29;
    localparam int DIV_CELLS        = 64;
    localparam int SQRT_CELLS       = 32;
    localparam int LATENCY = 3 + SQRT_CELLS + 7 * (DIV_CELLS + 2) + 1 + 3 + 3 + 6 + 5;

    typedef logic signed [63:0] t_s64;

    localparam logic [1:0] OP_ATAN  = 2'd0;
    localparam logic [1:0] OP_ATAN2 = 2'd1;
    localparam logic [1:0] OP_ASIN  = 2'd2;
    localparam logic [1:0] OP_ACOS  = 2'd3;

    localparam logic [1:0] MODE_DIRECT = 2'd0;
    localparam logic [1:0] MODE_POS    = 2'd1;
    localparam logic [1:0] MODE_NEG    = 2'd2;

    localparam t_s64 ONE_Q30     = 64'sd1 <<< 30;
    localparam t_s64 PI_Q30      = 64'sd3373259426;
    localparam t_s64 HALF_PI_Q30 = 64'sd1686629713;
    // The first level divides by -0.10810675, reduced to 4000000 / 432427.
    // The quotient is estimated with a reciprocal scaled by 2^50 and then
    // corrected by at most two compare steps.
    localparam t_s64        C0_MUL   = 64'sd4000000;
    localparam t_s64        C0_HALF  = 64'sd216213;
    localparam logic [63:0] C0_DIV   = 64'd432427;
    localparam logic [63:0] C0_DIV2  = 64'd864854;
    localparam logic [63:0] C0_RECIP = 64'd2603676243;
    localparam t_s64 CF_C1 = -(((64'sd4457192 <<< 30) + 64'sd50000) / 64'sd100000);
    localparam t_s64 CF_C2 = -(((64'sd1619081 <<< 30) + 64'sd5000000) / 64'sd10000000);
    localparam t_s64 CF_C3 = -(((64'sd15774018 <<< 30) + 64'sd500000) / 64'sd1000000);
    localparam t_s64 CF_C4 = -(((64'sd55556977 <<< 30) + 64'sd50000000) / 64'sd100000000);
    localparam t_s64 CF_C5 = -(((64'sd3000003 <<< 30) + 64'sd500000) / 64'sd1000000);
    localparam t_s64 SAT_MAX = 64'sd2147483647;
    localparam t_s64 SAT_MIN = -64'sd2147483648;

    localparam t_s64 ARG_ONE   = 64'sd1 <<< INPUT_FRAC_BITS;
    localparam t_s64 RECIP_NUM = 64'sd1 <<< (30 + INPUT_FRAC_BITS);
    localparam t_s64 CLAMP_THR = 64'sd99999 <<< INPUT_FRAC_BITS;
    localparam logic [63:0] SQ_ONE  = 64'd1 << (2 * INPUT_FRAC_BITS);
    localparam int          SQ_SHIFT = 60 - 2 * INPUT_FRAC_BITS;
    localparam logic [63:0] SQ_BIT0 = 64'd1 << 62;
    localparam int T_SHIFT   = 30 - INPUT_FRAC_BITS;
    localparam int OUT_SHIFT = 30 - OUTPUT_FRAC_BITS;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic               hi;
        logic               lo;
        logic [1:0]         mode;
        logic signed [31:0] t;
        logic signed [31:0] s;
    } t_ctx;

    typedef struct packed {
        logic        v;
        t_ctx        ctx;
        logic [63:0] rem;
        logic [63:0] nq;
        logic [63:0] d;
        logic        neg;
        logic        dz;
    } t_div_st;

    typedef struct packed {
        logic        v;
        t_ctx        ctx;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
    } t_sq_st;

    function automatic logic signed [31:0] sat32(input t_s64 v);
        if (v > SAT_MAX) begin
            return 32'sh7FFFFFFF;
        end
        if (v < SAT_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic t_s64 rnd_shift(input t_s64 v, input int sh);
        t_s64 bias;
        bias = (64'sd1 <<< (sh - 1)) - t_s64'({63'd0, v[63]});
        return (v + bias) >>> sh;
    endfunction

    function automatic t_s64 cf_add(input logic [2:0] k);
        case (k)
            3'd0: cf_add = CF_C2;
            3'd1: cf_add = CF_C3;
            3'd2: cf_add = CF_C4;
            3'd3: cf_add = CF_C5;
            default: cf_add = ONE_Q30;
        endcase
    endfunction

endpackage

### design/itu_div_cell.sv
// One restoring division cell: develops one quotient bit per item per cycle.
// Depends on itu_pkg.
module itu_div_cell import itu_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_div_st i_st,
    output t_div_st o_st
);

    logic [64:0] w_shift;
    logic [64:0] w_trial;
    logic        w_take;
    t_div_st     n_st;
    t_div_st     r_st;

    always_comb begin
        w_shift = {i_st.rem, i_st.nq[63]};
        w_trial = w_shift - {1'b0, i_st.d};
        w_take  = w_shift >= {1'b0, i_st.d};
        n_st     = i_st;
        n_st.rem = w_take ? w_trial[63:0] : w_shift[63:0];
        n_st.nq  = {i_st.nq[62:0], w_take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.v <= 1'b0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

### design/itu_sqrt_cell.sv
// One integer square root cell: settles one root bit per item per cycle.
// Depends on itu_pkg.
module itu_sqrt_cell import itu_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_sq_st i_st,
    output t_sq_st o_st
);

    logic [63:0] w_rb;
    t_sq_st      n_st;
    t_sq_st      r_st;

    always_comb begin
        w_rb = i_st.r + i_st.b;
        n_st = i_st;
        if (i_st.n >= w_rb) begin
            n_st.n = i_st.n - w_rb;
            n_st.r = (i_st.r >> 1) + i_st.b;
        end else begin
            n_st.r = i_st.r >> 1;
        end
        n_st.b = i_st.b >> 2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.v <= 1'b0;
        end else begin
            r_st <= n_st;
        end
    end

    assign o_st = r_st;

endmodule

### design/itu_divider.sv
// Pipelined signed divider with rounding to nearest, ties away from zero.
// Depends on itu_pkg and itu_div_cell; a zero divisor gives zero.
module itu_divider import itu_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_ctx i_ctx,
    input  t_s64 i_num,
    input  t_s64 i_den,
    output logic o_valid,
    output t_ctx o_ctx,
    output t_s64 o_quo
);

    logic [63:0] w_un;
    logic [63:0] w_ud;
    t_div_st     n_pre;
    t_div_st     r_pre;
    t_div_st     w_chain [DIV_CELLS + 1];
    t_div_st     w_last;
    logic        r_valid;
    t_ctx        r_ctx;
    t_s64        r_quo;

    always_comb begin
        w_un = i_num[63] ? 64'(-i_num) : 64'(i_num);
        w_ud = i_den[63] ? 64'(-i_den) : 64'(i_den);
        n_pre.v   = i_valid;
        n_pre.ctx = i_ctx;
        n_pre.rem = 64'd0;
        n_pre.nq  = w_un + (w_ud >> 1);
        n_pre.d   = w_ud;
        n_pre.neg = i_num[63] ^ i_den[63];
        n_pre.dz  = (i_den == 64'sd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre.v <= 1'b0;
        end else begin
            r_pre <= n_pre;
        end
    end

    assign w_chain[0] = r_pre;

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_cell
        itu_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_st    (w_chain[i]),
            .o_st    (w_chain[i + 1])
        );
    end

    assign w_last = w_chain[DIV_CELLS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_last.v;
            r_ctx   <= w_last.ctx;
            if (w_last.dz) begin
                r_quo <= 64'sd0;
            end else if (w_last.neg) begin
                r_quo <= -t_s64'(w_last.nq);
            end else begin
                r_quo <= t_s64'(w_last.nq);
            end
        end
    end

    assign o_valid = r_valid;
    assign o_ctx   = r_ctx;
    assign o_quo   = r_quo;

endmodule

### design/inverse_trig_unit.sv
// Top level of the inverse trigonometric unit: atan, atan2, asin and acos.
// Depends on itu_pkg, itu_sqrt_cell, itu_divider and the assertion macros.
//
// Usage:
// A request is accepted at a rising edge with i_start high and o_busy low.
// It carries i_req_type (0 atan, 1 atan2, 2 asin, 3 acos) and the signed
// Q16.16 operands i_x_operand and i_y_operand (y is used by atan2 only).
// o_busy is always low: the datapath is a fully pipelined chain of cells,
// so a new item may enter in every cycle.
// Each item yields one angle in radians, signed Q2.29, on o_angle for exactly
// one cycle with o_done high. The path runs through the 32-cell square root
// chain and seven 66-stage divider chains in series (ratio, reciprocal and
// five continued fraction levels), plus a three-stage reciprocal multiply
// for the first continued fraction level and the other multiply and rounding
// stages.
// Results leave in acceptance order. The receiver cannot stall the unit and
// must take each result in the cycle it appears.
// A synchronous active-low reset clears every pipeline valid bit, dropping
// any items in flight; the data registers are not reset.
`include "inverse_trig_unit_defines.svh"
module inverse_trig_unit import itu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  logic [1:0]         i_req_type,
    input  logic signed [31:0] i_x_operand,
    input  logic signed [31:0] i_y_operand,
    output logic               o_done,
    output logic signed [31:0] o_angle
);

    t_ctx               n_p0_ctx;
    logic               r_p0_v;
    t_ctx               r_p0_ctx;
    logic [31:0]        w_absx;
    logic               r_p1_v;
    t_ctx               r_p1_ctx;
    logic [63:0]        r_p1_xsq;
    t_s64               r_p1_xs;
    t_sq_st             n_p2;
    t_sq_st             r_p2;
    t_sq_st             w_sq [SQRT_CELLS + 1];
    t_sq_st             w_sq_out;
    t_s64               w_x64;
    t_s64               w_y64;
    t_s64               n_d1_num;
    t_s64               n_d1_den;
    logic               w_d1_v;
    t_ctx               w_d1_ctx;
    t_s64               w_d1_q;
    logic               r_p3_v;
    t_ctx               r_p3_ctx;
    logic signed [31:0] r_p3_a;
    t_s64               w_a64;
    t_s64               n_d2_num;
    t_s64               n_d2_den;
    t_ctx               n_d2_ctx;
    logic               w_d2_v;
    t_ctx               w_d2_ctx;
    t_s64               w_d2_q;
    t_ctx               n_p4_ctx;
    logic               r_p4_v;
    t_ctx               r_p4_ctx;
    t_s64               r_p4_tsq;
    t_ctx               n_p5_ctx;
    logic               r_p5_v;
    t_ctx               r_p5_ctx;
    logic               r_p6_v;
    t_ctx               r_p6_ctx;
    t_s64               r_p6_num;
    logic               r_c1_v;
    t_ctx               r_c1_ctx;
    logic [51:0]        r_c1_m;
    logic [63:0]        r_c1_phi;
    logic [63:0]        r_c1_plo;
    logic               r_c2_v;
    t_ctx               r_c2_ctx;
    logic [51:0]        r_c2_m;
    logic [63:0]        r_c2_qe;
    logic               r_c3_v;
    t_ctx               r_c3_ctx;
    logic [63:0]        r_c3_qe;
    logic [63:0]        r_c3_rem;
    logic [63:0]        w_c0_q;
    logic               r_cf_v   [6];
    t_ctx               r_cf_ctx [6];
    t_s64               r_cf_val [6];
    logic signed [33:0] w_v5;
    logic signed [65:0] w_prod;
    logic               r_m1_v;
    t_ctx               r_m1_ctx;
    t_s64               r_m1_prod;
    logic               r_m2_v;
    t_ctx               r_m2_ctx;
    t_s64               r_m2_r;
    logic               r_m3_v;
    t_ctx               r_m3_ctx;
    t_s64               r_m3_at;
    t_s64               n_m4_ang;
    logic               r_m4_v;
    t_s64               r_m4_ang;
    logic               r_done;
    logic signed [31:0] r_angle;

    assign o_busy = 1'b0;

    always_comb begin
        n_p0_ctx    = '0;
        n_p0_ctx.op = i_req_type;
        n_p0_ctx.x  = i_x_operand;
        n_p0_ctx.y  = i_y_operand;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
        end else begin
            r_p0_v   <= i_start & ~o_busy;
            r_p0_ctx <= n_p0_ctx;
        end
    end

    assign w_absx = r_p0_ctx.x[31] ? 32'(-r_p0_ctx.x) : 32'(r_p0_ctx.x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else begin
            r_p1_v   <= r_p0_v;
            r_p1_ctx <= r_p0_ctx;
            r_p1_xsq <= {32'd0, w_absx} * {32'd0, w_absx};
            r_p1_xs  <= t_s64'(r_p0_ctx.x) * 64'sd100000;
        end
    end

    always_comb begin
        n_p2        = '0;
        n_p2.v      = r_p1_v;
        n_p2.ctx    = r_p1_ctx;
        n_p2.ctx.hi = r_p1_xs > CLAMP_THR;
        n_p2.ctx.lo = r_p1_xs < -CLAMP_THR;
        n_p2.n      = (SQ_ONE - r_p1_xsq) << SQ_SHIFT;
        n_p2.r      = 64'd0;
        n_p2.b      = SQ_BIT0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2.v <= 1'b0;
        end else begin
            r_p2 <= n_p2;
        end
    end

    assign w_sq[0] = r_p2;

    for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sq
        itu_sqrt_cell u_sq (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_st    (w_sq[i]),
            .o_st    (w_sq[i + 1])
        );
    end

    assign w_sq_out = w_sq[SQRT_CELLS];

    always_comb begin
        w_x64 = t_s64'(w_sq_out.ctx.x);
        w_y64 = t_s64'(w_sq_out.ctx.y);
        case (w_sq_out.ctx.op)
            OP_ATAN: begin
                n_d1_num = w_x64;
                n_d1_den = 64'sd1;
            end
            OP_ATAN2: begin
                if (w_x64 < 64'sd0) begin
                    n_d1_num = (w_y64 < 64'sd0 ? -w_y64 : w_y64) <<< INPUT_FRAC_BITS;
                    n_d1_den = -w_x64;
                end else begin
                    n_d1_num = w_y64 <<< INPUT_FRAC_BITS;
                    n_d1_den = w_x64;
                end
            end
            default: begin
                n_d1_num = w_x64 <<< 30;
                n_d1_den = t_s64'(w_sq_out.r);
            end
        endcase
    end

    itu_divider u_d1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_out.v),
        .i_ctx   (w_sq_out.ctx),
        .i_num   (n_d1_num),
        .i_den   (n_d1_den),
        .o_valid (w_d1_v),
        .o_ctx   (w_d1_ctx),
        .o_quo   (w_d1_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_v <= 1'b0;
        end else begin
            r_p3_v   <= w_d1_v;
            r_p3_ctx <= w_d1_ctx;
            r_p3_a   <= sat32(w_d1_q);
        end
    end

    always_comb begin
        w_a64    = t_s64'(r_p3_a);
        n_d2_ctx = r_p3_ctx;
        if (w_a64 > ARG_ONE) begin
            n_d2_num      = RECIP_NUM;
            n_d2_den      = w_a64;
            n_d2_ctx.mode = MODE_POS;
        end else if (w_a64 < -ARG_ONE) begin
            n_d2_num      = RECIP_NUM;
            n_d2_den      = w_a64;
            n_d2_ctx.mode = MODE_NEG;
        end else begin
            n_d2_num      = w_a64 <<< T_SHIFT;
            n_d2_den      = 64'sd1;
            n_d2_ctx.mode = MODE_DIRECT;
        end
    end

    itu_divider u_d2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_p3_v),
        .i_ctx   (n_d2_ctx),
        .i_num   (n_d2_num),
        .i_den   (n_d2_den),
        .o_valid (w_d2_v),
        .o_ctx   (w_d2_ctx),
        .o_quo   (w_d2_q)
    );

    always_comb begin
        n_p4_ctx   = w_d2_ctx;
        n_p4_ctx.t = w_d2_q[31:0];
        n_p5_ctx   = r_p4_ctx;
        n_p5_ctx.s = 32'(rnd_shift(r_p4_tsq, 30));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_v <= 1'b0;
            r_p5_v <= 1'b0;
            r_p6_v <= 1'b0;
        end else begin
            r_p4_v   <= w_d2_v;
            r_p4_ctx <= n_p4_ctx;
            r_p4_tsq <= t_s64'(n_p4_ctx.t) * t_s64'(n_p4_ctx.t);
            r_p5_v   <= r_p4_v;
            r_p5_ctx <= n_p5_ctx;
            r_p6_v   <= r_p5_v;
            r_p6_ctx <= r_p5_ctx;
            r_p6_num <= t_s64'(r_p5_ctx.s) * C0_MUL + C0_HALF;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_v <= 1'b0;
            r_c2_v <= 1'b0;
            r_c3_v <= 1'b0;
        end else begin
            r_c1_v   <= r_p6_v;
            r_c1_ctx <= r_p6_ctx;
            r_c1_m   <= r_p6_num[51:0];
            r_c1_phi <= {38'd0, r_p6_num[51:26]} * C0_RECIP;
            r_c1_plo <= {38'd0, r_p6_num[25:0]} * C0_RECIP;
            r_c2_v   <= r_c1_v;
            r_c2_ctx <= r_c1_ctx;
            r_c2_m   <= r_c1_m;
            r_c2_qe  <= (r_c1_phi + (r_c1_plo >> 26)) >> 24;
            r_c3_v   <= r_c2_v;
            r_c3_ctx <= r_c2_ctx;
            r_c3_qe  <= r_c2_qe;
            r_c3_rem <= {12'd0, r_c2_m} - r_c2_qe * C0_DIV;
        end
    end

    assign w_c0_q = r_c3_qe + {63'd0, r_c3_rem >= C0_DIV} + {63'd0, r_c3_rem >= C0_DIV2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf_v[0] <= 1'b0;
        end else begin
            r_cf_v[0]   <= r_c3_v;
            r_cf_ctx[0] <= r_c3_ctx;
            r_cf_val[0] <= CF_C1 - t_s64'(w_c0_q);
        end
    end

    for (genvar k = 0; k < 5; k++) begin : g_cf
        logic w_v;
        t_ctx w_ctx;
        t_s64 w_q;

        itu_divider u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (r_cf_v[k]),
            .i_ctx   (r_cf_ctx[k]),
            .i_num   (t_s64'(r_cf_ctx[k].s) <<< 30),
            .i_den   (r_cf_val[k]),
            .o_valid (w_v),
            .o_ctx   (w_ctx),
            .o_quo   (w_q)
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cf_v[k + 1] <= 1'b0;
            end else begin
                r_cf_v[k + 1]   <= w_v;
                r_cf_ctx[k + 1] <= w_ctx;
                r_cf_val[k + 1] <= w_q + cf_add(3'(k));
            end
        end
    end

    assign w_v5   = r_cf_val[5][33:0];
    assign w_prod = w_v5 * r_cf_ctx[5].t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v <= 1'b0;
            r_m2_v <= 1'b0;
            r_m3_v <= 1'b0;
        end else begin
            r_m1_v    <= r_cf_v[5];
            r_m1_ctx  <= r_cf_ctx[5];
            r_m1_prod <= w_prod[63:0];
            r_m2_v    <= r_m1_v;
            r_m2_ctx  <= r_m1_ctx;
            r_m2_r    <= rnd_shift(r_m1_prod, 30);
            r_m3_v    <= r_m2_v;
            r_m3_ctx  <= r_m2_ctx;
            case (r_m2_ctx.mode)
                MODE_POS: r_m3_at <= HALF_PI_Q30 - r_m2_r;
                MODE_NEG: r_m3_at <= -HALF_PI_Q30 - r_m2_r;
                default:  r_m3_at <= r_m2_r;
            endcase
        end
    end

    always_comb begin
        case (r_m3_ctx.op)
            OP_ATAN: begin
                n_m4_ang = r_m3_at;
            end
            OP_ATAN2: begin
                if (r_m3_ctx.x > 32'sd0) begin
                    n_m4_ang = r_m3_at;
                end else if (r_m3_ctx.x < 32'sd0) begin
                    n_m4_ang = r_m3_ctx.y[31] ? (r_m3_at - PI_Q30) : (PI_Q30 - r_m3_at);
                end else if (r_m3_ctx.y != 32'sd0) begin
                    n_m4_ang = r_m3_ctx.y[31] ? -HALF_PI_Q30 : HALF_PI_Q30;
                end else begin
                    n_m4_ang = 64'sd0;
                end
            end
            OP_ASIN: begin
                if (r_m3_ctx.hi) begin
                    n_m4_ang = HALF_PI_Q30;
                end else if (r_m3_ctx.lo) begin
                    n_m4_ang = -HALF_PI_Q30;
                end else begin
                    n_m4_ang = r_m3_at;
                end
            end
            default: begin
                if (r_m3_ctx.hi) begin
                    n_m4_ang = 64'sd0;
                end else if (r_m3_ctx.lo) begin
                    n_m4_ang = PI_Q30;
                end else begin
                    n_m4_ang = HALF_PI_Q30 - r_m3_at;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m4_v <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_m4_v   <= r_m3_v;
            r_m4_ang <= n_m4_ang;
            r_done   <= r_m4_v;
            r_angle  <= 32'(rnd_shift(r_m4_ang, OUT_SHIFT));
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;

    `ITU_ASSERT_RST(a_latency_fwd, i_clk, i_rst_n, (i_start && !o_busy) |-> ##LATENCY o_done, "accepted item did not complete at the expected latency")
    `ITU_ASSERT_RST(a_latency_bwd, i_clk, i_rst_n, o_done |-> $past(i_start && !o_busy, LATENCY), "result appeared without a matching accepted item")
    `ITU_ASSERT_RST(a_sqrt_rem, i_clk, i_rst_n, w_sq_out.v |-> (w_sq_out.n <= (w_sq_out.r << 1)), "square root remainder out of range")
    `ITU_ASSERT_ALWAYS(a_reset_clear, i_clk, !i_rst_n |=> !o_done, "result strobe not cleared by reset")

endmodule
